FILE: sv/assert_macros.svh
// Assertion macros shared by the interval cover modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define GIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define GIC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: sv/gic_pkg.sv
// Package with types, constants and command/status structs of the interval cover block.
`timescale 1ns / 1ps
`default_nettype none
package gic_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned IdxW         = 6;
  localparam int unsigned CntW         = 7;
  localparam int unsigned ListDepth    = 64;
  localparam int unsigned ListAddrW    = $clog2(ListDepth);
  localparam int unsigned MaxIntervals = 64;
  localparam int unsigned CfgIdxW      = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTargetStart = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTargetEnd   = 1'b1;

  typedef struct packed {
    logic signed [DataW-1:0] interval_start;
    logic signed [DataW-1:0] interval_end;
    logic                    final_interval;
  } in_t;

  typedef struct packed {
    logic [IdxW-1:0] chosen_index;
    logic [CntW-1:0] cover_count;
    logic            impossible;
    logic            run_end;
  } out_t;

  typedef struct packed {
    logic load;
    logic pass_init;
    logic scan_rd;
    logic next_pass;
    logic append;
    logic set_fail;
    logic clear_set;
    logic emit_rd;
  } cmd_t;

  typedef struct packed {
    logic final_req;
    logic scan_more;
    logic scan_pend;
    logic fail;
    logic reached;
    logic stalled;
    logic emit_more;
  } status_t;

endpackage
`default_nettype wire

FILE: sv/gic_ctrl.sv
// Controller state machine: load, greedy scan passes, pass decision, result emission.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gic_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire gic_pkg::status_t st_i,
  output gic_pkg::cmd_t         cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_d, state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (st_i.final_req) begin
            cmd_o.pass_init = 1'b1;
            state_d         = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.scan_rd = st_i.scan_more;
        if (!st_i.scan_more && !st_i.scan_pend) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st_i.fail) begin
          cmd_o.set_fail  = 1'b1;
          cmd_o.clear_set = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.append = 1'b1;
          if (st_i.reached) begin
            cmd_o.clear_set = 1'b1;
            state_d         = S_EMIT;
          end else if (st_i.stalled) begin
            // no progress past the covered point
            cmd_o.set_fail  = 1'b1;
            cmd_o.clear_set = 1'b1;
            state_d         = S_IDLE;
          end else begin
            cmd_o.next_pass = 1'b1;
            state_d         = S_READ;
          end
        end
      end
      S_EMIT: begin
        cmd_o.emit_rd = st_i.emit_more;
        if (!st_i.emit_more) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  `GIC_ASSERT(a_final_starts_scan, start_i && !busy_o && st_i.final_req |=> state_q == S_READ, "final request did not start a scan")
  `GIC_ASSERT(a_decide_one_cycle, state_q == S_DECIDE |=> state_q != S_DECIDE, "decision held for more than one cycle")
  `GIC_ASSERT_NEVER(a_emit_and_scan, cmd_o.emit_rd && cmd_o.scan_rd, "emission overlaps scan")

endmodule
`default_nettype wire

FILE: sv/gic_datapath.sv
// Datapath: target registers, interval store, best-candidate scan, chosen list and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module gic_datapath #(
  parameter int unsigned MaxIntervals = gic_pkg::MaxIntervals
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire gic_pkg::in_t                 req_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [gic_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [gic_pkg::DataW-1:0]    cfg_data_i,
  input  wire gic_pkg::cmd_t                cmd_i,
  output gic_pkg::status_t                  st_o,
  output logic                              res_strobe_o,
  output gic_pkg::out_t                     res_o
);

  localparam int unsigned AddrW = (MaxIntervals > 1) ? $clog2(MaxIntervals) : 1;
  localparam int unsigned CntLW = $clog2(MaxIntervals + 1);
  localparam int unsigned DW    = gic_pkg::DataW;
  localparam int unsigned IW    = gic_pkg::IdxW;
  localparam int unsigned CW    = gic_pkg::CntW;
  localparam int unsigned LAW   = gic_pkg::ListAddrW;

  // interval store: {start, end}, clipped at arrival
  logic [2*DW-1:0] ivl_mem [MaxIntervals];
  logic [IW-1:0]   list_mem [gic_pkg::ListDepth];

  logic signed [DW-1:0] tgt_start_q, tgt_end_q;
  logic [CntLW-1:0]     loaded_q;
  logic [CntLW-1:0]     raddr_q;
  logic [AddrW-1:0]     rd_addr_q;
  logic                 rvld_q;
  logic [2*DW-1:0]      rdata_q;
  logic signed [DW-1:0] covered_q, prev_q, best_end_q, best_start_q;
  logic                 first_q, found_q;
  logic [IW-1:0]        best_idx_q;
  logic [CW-1:0]        count_q, ek_q;
  logic                 out_vld_q;
  gic_pkg::out_t        out_q;

  logic signed [DW-1:0] s_clip, e_clip, rd_s, rd_e;
  logic                 has_room, cand, better;
  logic [AddrW+IW-1:0]  idx_ext;

  always_comb begin
    s_clip = (req_i.interval_start < tgt_start_q) ? tgt_start_q : req_i.interval_start;
    e_clip = (req_i.interval_end > tgt_end_q) ? tgt_end_q : req_i.interval_end;
  end

  assign has_room = (loaded_q < CntLW'(MaxIntervals));
  assign rd_s     = rdata_q[2*DW-1:DW];
  assign rd_e     = rdata_q[DW-1:0];
  assign idx_ext  = {{IW{1'b0}}, rd_addr_q};

  // candidates start at or before the covered point and were not candidates in an earlier pass
  assign cand   = rvld_q && (rd_s <= covered_q) && (first_q || (rd_s > prev_q));
  assign better = !found_q || (rd_e > best_end_q) ||
                  ((rd_e == best_end_q) && (rd_s < best_start_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && has_room) begin
      ivl_mem[loaded_q[AddrW-1:0]] <= {s_clip, e_clip};
    end
    if (cmd_i.scan_rd) begin
      rdata_q <= ivl_mem[raddr_q[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      list_mem[count_q[LAW-1:0]] <= best_idx_q;
    end
    if (cmd_i.emit_rd) begin
      out_q.chosen_index <= list_mem[ek_q[LAW-1:0]];
      out_q.cover_count  <= count_q;
      out_q.impossible   <= 1'b0;
      out_q.run_end      <= ((ek_q + CW'(1)) == count_q);
    end else if (cmd_i.set_fail) begin
      out_q.chosen_index <= '0;
      out_q.cover_count  <= '0;
      out_q.impossible   <= 1'b1;
      out_q.run_end      <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_start_q  <= '0;
      tgt_end_q    <= '0;
      loaded_q     <= '0;
      raddr_q      <= '0;
      rd_addr_q    <= '0;
      rvld_q       <= 1'b0;
      covered_q    <= '0;
      prev_q       <= '0;
      best_end_q   <= '0;
      best_start_q <= '0;
      first_q      <= 1'b0;
      found_q      <= 1'b0;
      best_idx_q   <= '0;
      count_q      <= '0;
      ek_q         <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          gic_pkg::CfgTargetStart: tgt_start_q <= cfg_data_i;
          gic_pkg::CfgTargetEnd:   tgt_end_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load && has_room) begin
        loaded_q <= loaded_q + CntLW'(1);
      end
      if (cmd_i.clear_set) begin
        loaded_q <= '0;
      end

      rvld_q <= cmd_i.scan_rd;
      if (cmd_i.scan_rd) begin
        rd_addr_q <= raddr_q[AddrW-1:0];
        raddr_q   <= raddr_q + CntLW'(1);
      end

      if (cand && better) begin
        found_q      <= 1'b1;
        best_end_q   <= rd_e;
        best_start_q <= rd_s;
        best_idx_q   <= idx_ext[IW-1:0];
      end

      if (cmd_i.pass_init) begin
        covered_q <= tgt_start_q;
        first_q   <= 1'b1;
        found_q   <= 1'b0;
        raddr_q   <= '0;
        count_q   <= '0;
        ek_q      <= '0;
      end
      if (cmd_i.next_pass) begin
        prev_q    <= covered_q;
        covered_q <= best_end_q;
        first_q   <= 1'b0;
        found_q   <= 1'b0;
        raddr_q   <= '0;
      end
      if (cmd_i.append) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.emit_rd) begin
        ek_q <= ek_q + CW'(1);
      end
      out_vld_q <= cmd_i.emit_rd || cmd_i.set_fail;
    end
  end

  always_comb begin
    st_o           = '0;
    st_o.final_req = req_i.final_interval;
    st_o.scan_more = (raddr_q < loaded_q);
    st_o.scan_pend = rvld_q;
    st_o.fail      = !found_q || (best_end_q < covered_q) ||
                     (count_q >= CW'(gic_pkg::ListDepth));
    st_o.reached   = (best_end_q >= tgt_end_q);
    st_o.stalled   = (best_end_q == covered_q);
    st_o.emit_more = (ek_q < count_q);
  end

  assign res_strobe_o = out_vld_q;
  assign res_o        = out_q;

  `GIC_ASSERT(a_count_bound, count_q <= CW'(gic_pkg::ListDepth), "chosen count beyond list depth")
  `GIC_ASSERT(a_read_follows_issue, rvld_q |-> $past(cmd_i.scan_rd), "scan data without a read")
  `GIC_ASSERT(a_cover_from_list, out_vld_q && !out_q.impossible |-> $past(cmd_i.emit_rd), "cover result without list read")

endmodule
`default_nettype wire

FILE: sv/greedy_interval_cover.sv
// A non-final request leaves busy low, so one is taken per cycle.
// Final request: greedy passes over the N stored intervals
// (one store read a cycle per pass, then the read drains and the pass is decided),
// then the C chosen indices are streamed out.
// Reset: targets, counts and control clear at once; the stores need no clearing.
// Results cannot be stalled by the receiver; one strobe per result, impossible right after.
`timescale 1ns / 1ps
`default_nettype none
module greedy_interval_cover #(
  parameter int unsigned MaxIntervals = gic_pkg::MaxIntervals
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire gic_pkg::in_t                req_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [gic_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [gic_pkg::DataW-1:0]   cfg_data_i,
  output logic                             res_strobe_o,
  output gic_pkg::out_t                    res_o
);

  gic_pkg::cmd_t    cmd;
  gic_pkg::status_t st;

  assign cfg_ready_o = 1'b1;

  gic_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .st_i    (st),
    .cmd_o   (cmd)
  );

  gic_datapath #(
    .MaxIntervals (MaxIntervals)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .st_o         (st),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule
`default_nettype wire
